/* sv/cdwg_pkg.sv */
// Shared types, register indexes and helpers of the clipped draw window generator.
package cdwg_pkg;

   localparam int SegCount  = 4;
   localparam int SelBits   = $clog2(SegCount);
   localparam int PosBits   = 18;
   localparam int DimBits   = 11;
   localparam int LimitBits = 22;

   typedef logic [2:0]             csr_index_type;
   typedef logic [2:0]             req_code_type;
   typedef logic signed [PosBits-1:0] pos_type;
   typedef logic [DimBits-1:0]     dim_type;

   localparam dim_type DimCap = 11'd1024;

   localparam csr_index_type CsrClipXMin    = 3'd0;
   localparam csr_index_type CsrClipYMin    = 3'd1;
   localparam csr_index_type CsrClipXMax    = 3'd2;
   localparam csr_index_type CsrClipYMax    = 3'd3;
   localparam csr_index_type CsrPanelWidth  = 3'd4;
   localparam csr_index_type CsrPanelHeight = 3'd5;

   localparam req_code_type ReqPixel   = 3'd0;
   localparam req_code_type ReqFill    = 3'd1;
   localparam req_code_type ReqOutline = 3'd2;
   localparam req_code_type ReqHline   = 3'd3;
   localparam req_code_type ReqVline   = 3'd4;
   localparam req_code_type ReqClear   = 3'd5;

   // half-open box before clipping
   typedef struct packed {
      pos_type x0;
      pos_type y0;
      pos_type x1;
      pos_type y1;
   } box_type;

   // drawable region, already capped and intersected with the panel
   typedef struct packed {
      logic [9:0] x_lo;
      logic [9:0] y_lo;
      dim_type    x_hi;
      dim_type    y_hi;
      dim_type    panel_w;
      dim_type    panel_h;
   } bounds_type;

   // one clipped, non-empty window headed for the back end
   typedef struct packed {
      dim_type     x0;
      dim_type     y0;
      dim_type     x1;
      dim_type     y1;
      logic [15:0] color;
      logic        last;
   } seg_type;

   function automatic logic [15:0] pack_bgr565(logic [23:0] rgb);
      return {rgb[7:3], rgb[15:10], rgb[23:19]};
   endfunction

   function automatic dim_type cap_dim(dim_type v);
      return (v > DimCap) ? DimCap : v;
   endfunction

endpackage

/* sv/cdwg_front.sv */
// Front end: takes draw requests, builds up to four boxes, clips them and issues windows.
module cdwg_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_type,
   input  logic signed [15:0]     req_pos_x,
   input  logic signed [15:0]     req_pos_y,
   input  logic [15:0]            req_len_x,
   input  logic [15:0]            req_len_y,
   input  logic [7:0]             req_thickness,
   input  logic [23:0]            req_color_rgb,
   input  cdwg_pkg::bounds_type   bounds,
   output logic                   seg_valid,
   input  logic                   seg_ready,
   output cdwg_pkg::seg_type      seg
);

   typedef struct packed {
      cdwg_pkg::dim_type x0;
      cdwg_pkg::dim_type y0;
      cdwg_pkg::dim_type x1;
      cdwg_pkg::dim_type y1;
   } win_type;

   localparam cdwg_pkg::pos_type PosOne = 18'sd1;

   // stage 1: raw boxes of the accepted item
   logic                                 s1_valid_ff, s1_valid_in;
   cdwg_pkg::box_type                    s1_box_ff [cdwg_pkg::SegCount];
   cdwg_pkg::box_type                    box_in    [cdwg_pkg::SegCount];
   logic [cdwg_pkg::SegCount-1:0]        s1_mask_ff, mask_in;
   logic [15:0]                          s1_color_ff;

   // stage 2: clipped windows, drained one per cycle while seg_ready is high
   logic [cdwg_pkg::SegCount-1:0]        s2_mask_ff, s2_mask_in;
   win_type                              s2_win_ff [cdwg_pkg::SegCount];
   win_type                              clip_win  [cdwg_pkg::SegCount];
   logic [cdwg_pkg::SegCount-1:0]        live;
   logic [15:0]                          s2_color_ff;

   logic [cdwg_pkg::SelBits-1:0]         sel;
   logic [cdwg_pkg::SegCount-1:0]        rest;
   logic                                 push, s2_free, req_fire, s1_move;

   always_comb begin
      cdwg_pkg::pos_type px, py, plx, ply, th, th_half, xe, ye;
      px      = {{2{req_pos_x[15]}}, req_pos_x};
      py      = {{2{req_pos_y[15]}}, req_pos_y};
      plx     = {2'b00, req_len_x};
      ply     = {2'b00, req_len_y};
      th      = {10'd0, req_thickness};
      th_half = {11'd0, req_thickness[7:1]};
      xe      = px + plx;
      ye      = py + ply;
      for (int k = 0; k < cdwg_pkg::SegCount; k++) begin
         box_in[k] = '0;
      end
      mask_in = '0;
      unique case (req_type)
         cdwg_pkg::ReqPixel: begin
            box_in[0] = '{x0: px, y0: py, x1: px + PosOne, y1: py + PosOne};
            mask_in   = 4'b0001;
         end
         cdwg_pkg::ReqFill: begin
            box_in[0] = '{x0: px, y0: py, x1: xe, y1: ye};
            mask_in   = 4'b0001;
         end
         cdwg_pkg::ReqOutline: begin
            // top, bottom, left, right; side columns skip the corner rows
            box_in[0] = '{x0: px, y0: py, x1: xe, y1: py + PosOne};
            box_in[1] = '{x0: px, y0: ye - PosOne, x1: xe, y1: ye};
            box_in[2] = '{x0: px, y0: py + PosOne, x1: px + PosOne, y1: ye - PosOne};
            box_in[3] = '{x0: xe - PosOne, y0: py + PosOne, x1: xe, y1: ye - PosOne};
            if (req_len_x != '0 && req_len_y != '0) begin
               mask_in = {req_len_x >= 16'd2, 1'b1, req_len_y >= 16'd2, 1'b1};
            end
         end
         cdwg_pkg::ReqHline: begin
            box_in[0] = '{x0: px, y0: py - th_half, x1: xe, y1: py - th_half + th};
            mask_in   = 4'b0001;
         end
         cdwg_pkg::ReqVline: begin
            box_in[0] = '{x0: px - th_half, y0: py, x1: px - th_half + th, y1: ye};
            mask_in   = 4'b0001;
         end
         cdwg_pkg::ReqClear: begin
            box_in[0] = '{x0: '0, y0: '0,
                          x1: {7'd0, bounds.panel_w}, y1: {7'd0, bounds.panel_h}};
            mask_in   = 4'b0001;
         end
         default: begin
            mask_in = '0;
         end
      endcase
   end

   // clip all four boxes side by side
   always_comb begin
      cdwg_pkg::pos_type lo_x, lo_y, hi_x, hi_y, cx0, cy0, cx1, cy1;
      lo_x = {8'd0, bounds.x_lo};
      lo_y = {8'd0, bounds.y_lo};
      hi_x = {7'd0, bounds.x_hi};
      hi_y = {7'd0, bounds.y_hi};
      for (int k = 0; k < cdwg_pkg::SegCount; k++) begin
         cx0 = (s1_box_ff[k].x0 < lo_x) ? lo_x : s1_box_ff[k].x0;
         cy0 = (s1_box_ff[k].y0 < lo_y) ? lo_y : s1_box_ff[k].y0;
         cx1 = (s1_box_ff[k].x1 > hi_x) ? hi_x : s1_box_ff[k].x1;
         cy1 = (s1_box_ff[k].y1 > hi_y) ? hi_y : s1_box_ff[k].y1;
         live[k] = s1_mask_ff[k] && (cx0 < cx1) && (cy0 < cy1);
         // a live box lies within 0..1024, so 11 bits hold it
         clip_win[k] = '{x0: cx0[cdwg_pkg::DimBits-1:0], y0: cy0[cdwg_pkg::DimBits-1:0],
                         x1: cx1[cdwg_pkg::DimBits-1:0], y1: cy1[cdwg_pkg::DimBits-1:0]};
      end
   end

   always_comb begin
      sel = '0;
      for (int k = cdwg_pkg::SegCount - 1; k >= 0; k--) begin
         if (s2_mask_ff[k]) begin
            sel = cdwg_pkg::SelBits'(k);
         end
      end
   end

   assign rest      = s2_mask_ff & ~(cdwg_pkg::SegCount'(1) << sel);
   assign seg_valid = (s2_mask_ff != '0);
   assign push      = seg_valid && seg_ready;
   assign s2_free   = !seg_valid || (push && rest == '0);
   assign s1_move   = s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s2_free;
   assign req_fire  = req_valid && req_ready;

   assign seg = '{x0: s2_win_ff[sel].x0, y0: s2_win_ff[sel].y0,
                  x1: s2_win_ff[sel].x1, y1: s2_win_ff[sel].y1,
                  color: s2_color_ff, last: (rest == '0)};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s2_free) begin
         s1_valid_in = 1'b0;
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
      s2_mask_in = s2_mask_ff;
      if (push) begin
         s2_mask_in = rest;
      end
      if (s1_move) begin
         s2_mask_in = live;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_mask_ff  <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_mask_ff  <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_box_ff   <= box_in;
         s1_mask_ff  <= mask_in;
         s1_color_ff <= cdwg_pkg::pack_bgr565(req_color_rgb);
      end
      if (s1_move) begin
         s2_win_ff   <= clip_win;
         s2_color_ff <= s1_color_ff;
      end
   end

endmodule

/* sv/cdwg_queue.sv */
// Small window queue between the front and back ends.
module cdwg_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  cdwg_pkg::seg_type  in_seg,
   output logic               out_valid,
   input  logic               out_ready,
   output cdwg_pkg::seg_type  out_seg
);

   localparam int PtrBits = $clog2(DEPTH);
   localparam int CntBits = $clog2(DEPTH + 1);

   cdwg_pkg::seg_type   entry_ff [DEPTH];
   logic [PtrBits-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CntBits'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_seg   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_seg;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(DEPTH))
      else $error("queue count above depth");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not follow a pop");

endmodule

/* sv/cdwg_back.sv */
// Back end: sizes each window, checks it against the area limit and holds the result.
module cdwg_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              seg_valid,
   output logic                              seg_ready,
   input  cdwg_pkg::seg_type                 seg,
   input  logic [cdwg_pkg::LimitBits-1:0]    limit,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [15:0]                       rsp_win_x0,
   output logic [15:0]                       rsp_win_y0,
   output logic [15:0]                       rsp_win_x1,
   output logic [15:0]                       rsp_win_y1,
   output logic [20:0]                       rsp_pixel_count,
   output logic [15:0]                       rsp_color_packed,
   output logic                              rsp_refused,
   output logic                              rsp_last_segment
);

   localparam logic [15:0] CoordMask = 16'((32'd1 << COORD_BITS) - 1);

   logic                               b1_valid_ff, b1_valid_in;
   cdwg_pkg::dim_type                  b1_x0_ff, b1_y0_ff, b1_x1_ff, b1_y1_ff;
   cdwg_pkg::dim_type                  b1_w_ff, b1_h_ff;
   logic [15:0]                        b1_color_ff;
   logic                               b1_last_ff;

   logic                               out_valid_ff, out_valid_in;
   logic                               advance, b1_take, refused;
   logic [cdwg_pkg::LimitBits-1:0]     count;

   assign advance   = !out_valid_ff || rsp_ready;
   assign b1_take   = !b1_valid_ff || advance;
   assign seg_ready = b1_take;

   assign count   = cdwg_pkg::LimitBits'(b1_w_ff) * cdwg_pkg::LimitBits'(b1_h_ff);
   assign refused = (count > limit);

   always_comb begin
      b1_valid_in  = b1_valid_ff;
      out_valid_in = out_valid_ff;
      if (b1_take) begin
         b1_valid_in = seg_valid;
      end
      if (advance) begin
         out_valid_in = b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b1_take && seg_valid) begin
         b1_x0_ff    <= seg.x0;
         b1_y0_ff    <= seg.y0;
         b1_x1_ff    <= seg.x1 - 1'b1;
         b1_y1_ff    <= seg.y1 - 1'b1;
         b1_w_ff     <= seg.x1 - seg.x0;
         b1_h_ff     <= seg.y1 - seg.y0;
         b1_color_ff <= seg.color;
         b1_last_ff  <= seg.last;
      end
      if (advance && b1_valid_ff) begin
         rsp_win_x0       <= 16'(b1_x0_ff) & CoordMask;
         rsp_win_y0       <= 16'(b1_y0_ff) & CoordMask;
         rsp_win_x1       <= 16'(b1_x1_ff) & CoordMask;
         rsp_win_y1       <= 16'(b1_y1_ff) & CoordMask;
         rsp_pixel_count  <= refused ? '0 : count[20:0];
         rsp_refused      <= refused;
         rsp_color_packed <= b1_color_ff;
         rsp_last_segment <= b1_last_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_refused) |-> (rsp_pixel_count != '0))
      else $error("window with no pixels reached the output");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_win_x1 >= rsp_win_x0 && rsp_win_y1 >= rsp_win_y0))
      else $error("window corners out of order");

endmodule

/* sv/clipped_draw_window_generator_unit.sv */
// Clipped draw window generator: a request enters every cycle the front end is free. Its boxes
// are clipped in one pass and the resulting windows leave the front end one per cycle while the
// queue accepts them, so a request holds the front end for as many windows as it yields (an
// outline rectangle up to four, all other kinds at most one). That one-window-per-cycle issue step
// sets the rate; a queue of QUEUE_DEPTH windows and a two-stage back end (size, then multiply and
// limit check into the output register) follow. Register writes apply to every request taken
// after the write edge.
module clipped_draw_window_generator_unit #(
   parameter int COORD_BITS  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_type,
   input  logic signed [15:0]  req_pos_x,
   input  logic signed [15:0]  req_pos_y,
   input  logic [15:0]         req_len_x,
   input  logic [15:0]         req_len_y,
   input  logic [7:0]          req_thickness,
   input  logic [23:0]         req_color_rgb,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_win_x0,
   output logic [15:0]         rsp_win_y0,
   output logic [15:0]         rsp_win_x1,
   output logic [15:0]         rsp_win_y1,
   output logic [20:0]         rsp_pixel_count,
   output logic [15:0]         rsp_color_packed,
   output logic                rsp_refused,
   output logic                rsp_last_segment,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  cdwg_pkg::csr_index_type csr_index,
   input  logic [10:0]         csr_wdata
);

   logic [9:0]                       clip_x_min_ff, clip_y_min_ff;
   cdwg_pkg::dim_type                clip_x_max_ff, clip_y_max_ff;
   cdwg_pkg::dim_type                panel_width_ff, panel_height_ff;
   cdwg_pkg::dim_type                pw_cap, ph_cap, cx_cap, cy_cap;
   logic [cdwg_pkg::LimitBits-1:0]   area_prod;
   logic [cdwg_pkg::LimitBits-1:0]   limit_ff, limit_in;
   cdwg_pkg::bounds_type             bounds;

   logic                             q_in_valid, q_in_ready, q_out_valid, q_out_ready;
   cdwg_pkg::seg_type                q_in_seg, q_out_seg;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_x_min_ff   <= 10'd0;
         clip_y_min_ff   <= 10'd0;
         clip_x_max_ff   <= 11'd320;
         clip_y_max_ff   <= 11'd240;
         panel_width_ff  <= 11'd320;
         panel_height_ff <= 11'd240;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cdwg_pkg::CsrClipXMin:    clip_x_min_ff   <= csr_wdata[9:0];
            cdwg_pkg::CsrClipYMin:    clip_y_min_ff   <= csr_wdata[9:0];
            cdwg_pkg::CsrClipXMax:    clip_x_max_ff   <= csr_wdata;
            cdwg_pkg::CsrClipYMax:    clip_y_max_ff   <= csr_wdata;
            cdwg_pkg::CsrPanelWidth:  panel_width_ff  <= csr_wdata;
            cdwg_pkg::CsrPanelHeight: panel_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign pw_cap = cdwg_pkg::cap_dim(panel_width_ff);
   assign ph_cap = cdwg_pkg::cap_dim(panel_height_ff);
   assign cx_cap = cdwg_pkg::cap_dim(clip_x_max_ff);
   assign cy_cap = cdwg_pkg::cap_dim(clip_y_max_ff);

   assign bounds = '{x_lo:    clip_x_min_ff,
                     y_lo:    clip_y_min_ff,
                     x_hi:    (pw_cap < cx_cap) ? pw_cap : cx_cap,
                     y_hi:    (ph_cap < cy_cap) ? ph_cap : cy_cap,
                     panel_w: pw_cap,
                     panel_h: ph_cap};

   // twice the panel area; at most 2^21
   assign area_prod = cdwg_pkg::LimitBits'(pw_cap) * cdwg_pkg::LimitBits'(ph_cap);
   assign limit_in  = {area_prod[cdwg_pkg::LimitBits-2:0], 1'b0};

   always_ff @(posedge clock) begin
      limit_ff <= limit_in;
   end

   cdwg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_len_x     (req_len_x),
      .req_len_y     (req_len_y),
      .req_thickness (req_thickness),
      .req_color_rgb (req_color_rgb),
      .bounds        (bounds),
      .seg_valid     (q_in_valid),
      .seg_ready     (q_in_ready),
      .seg           (q_in_seg)
   );

   cdwg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_in_valid),
      .in_ready  (q_in_ready),
      .in_seg    (q_in_seg),
      .out_valid (q_out_valid),
      .out_ready (q_out_ready),
      .out_seg   (q_out_seg)
   );

   cdwg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .seg_valid        (q_out_valid),
      .seg_ready        (q_out_ready),
      .seg              (q_out_seg),
      .limit            (limit_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_win_x0       (rsp_win_x0),
      .rsp_win_y0       (rsp_win_y0),
      .rsp_win_x1       (rsp_win_x1),
      .rsp_win_y1       (rsp_win_y1),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_color_packed (rsp_color_packed),
      .rsp_refused      (rsp_refused),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

/* verif/clipped_draw_window_generator_unit_tb.sv */
// Self-checking testbench for the clipped draw window generator: predicted windows vs. the block.
`timescale 1ns / 100ps

typedef struct {
   logic [2:0]         code;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        len_x;
   logic [15:0]        len_y;
   logic [7:0]         thickness;
   logic [23:0]        color;
} draw_req_type;

typedef struct {
   logic [15:0] x0;
   logic [15:0] y0;
   logic [15:0] x1;
   logic [15:0] y1;
   logic [20:0] count;
   logic [15:0] color;
   logic        refused;
   logic        last;
} window_type;

class draw_window_checker;
   logic [9:0]  clip_x_lo;
   logic [9:0]  clip_y_lo;
   logic [10:0] clip_x_hi;
   logic [10:0] clip_y_hi;
   logic [10:0] panel_w;
   logic [10:0] panel_h;
   window_type  staged[$];
   window_type  pending[$];
   int          mismatches;
   int          windows_checked;

   function new();
      clip_x_lo = 10'd0;
      clip_y_lo = 10'd0;
      clip_x_hi = 11'd320;
      clip_y_hi = 11'd240;
      panel_w   = 11'd320;
      panel_h   = 11'd240;
      mismatches = 0;
      windows_checked = 0;
   endfunction

   function void write_reg(cdwg_pkg::csr_index_type idx, logic [10:0] value);
      case (idx)
         cdwg_pkg::CsrClipXMin:    clip_x_lo = value[9:0];
         cdwg_pkg::CsrClipYMin:    clip_y_lo = value[9:0];
         cdwg_pkg::CsrClipXMax:    clip_x_hi = value;
         cdwg_pkg::CsrClipYMax:    clip_y_hi = value;
         cdwg_pkg::CsrPanelWidth:  panel_w   = value;
         cdwg_pkg::CsrPanelHeight: panel_h   = value;
         default: ;
      endcase
   endfunction

   function int capped(logic [10:0] v);
      return (v > 11'd1024) ? 1024 : int'(v);
   endfunction

   // clip a half-open box to the drawable region, stage a window if anything is left
   function void add_box(int x0, int y0, int x1, int y1, logic [15:0] color);
      int         ex0;
      int         ey0;
      int         ex1;
      int         ey1;
      int         pw;
      int         ph;
      longint     area;
      longint     limit;
      window_type w;
      if (staged.size() >= 4) return;
      ex0 = int'(clip_x_lo);
      ey0 = int'(clip_y_lo);
      ex1 = capped(clip_x_hi);
      ey1 = capped(clip_y_hi);
      pw  = capped(panel_w);
      ph  = capped(panel_h);
      if (pw < ex1) ex1 = pw;
      if (ph < ey1) ey1 = ph;
      if (x0 < ex0) x0 = ex0;
      if (y0 < ey0) y0 = ey0;
      if (x1 > ex1) x1 = ex1;
      if (y1 > ey1) y1 = ey1;
      if (x0 >= x1 || y0 >= y1) return;
      area  = longint'(x1 - x0) * longint'(y1 - y0);
      limit = 2 * longint'(pw) * longint'(ph);
      w.x0 = x0[15:0];
      w.y0 = y0[15:0];
      w.x1 = 16'(x1 - 1);
      w.y1 = 16'(y1 - 1);
      if (area > limit) begin
         w.count   = '0;
         w.refused = 1'b1;
      end else begin
         w.count   = area[20:0];
         w.refused = 1'b0;
      end
      w.color = color;
      w.last  = 1'b0;
      staged.push_back(w);
   endfunction

   function void note_request(draw_req_type r);
      int          x;
      int          y;
      int          lx;
      int          ly;
      int          t;
      int          h;
      logic [15:0] c;
      x  = int'(r.pos_x);
      y  = int'(r.pos_y);
      lx = int'(r.len_x);
      ly = int'(r.len_y);
      t  = int'(r.thickness);
      h  = t / 2;
      // blue to the top, red to the bottom
      c  = 16'((r.color >> 19) & 24'h1F) | 16'((r.color >> 5) & 24'h7E0)
         | 16'((r.color << 8) & 24'hF800);
      staged.delete();
      case (r.code)
         cdwg_pkg::ReqPixel: add_box(x, y, x + 1, y + 1, c);
         cdwg_pkg::ReqFill:  add_box(x, y, x + lx, y + ly, c);
         cdwg_pkg::ReqOutline: begin
            if (lx > 0 && ly > 0) begin
               add_box(x, y, x + lx, y + 1, c);
               if (ly >= 2) add_box(x, y + ly - 1, x + lx, y + ly, c);
               // side columns skip the corner rows
               add_box(x, y + 1, x + 1, y + ly - 1, c);
               if (lx >= 2) add_box(x + lx - 1, y + 1, x + lx, y + ly - 1, c);
            end
         end
         cdwg_pkg::ReqHline: add_box(x, y - h, x + lx, y - h + t, c);
         cdwg_pkg::ReqVline: add_box(x - h, y, x - h + t, y + ly, c);
         cdwg_pkg::ReqClear: add_box(0, 0, capped(panel_w), capped(panel_h), c);
         default: ;
      endcase
      if (staged.size() > 0) staged[staged.size() - 1].last = 1'b1;
      foreach (staged[i]) pending.push_back(staged[i]);
   endfunction

   function string show(window_type w);
      return $sformatf("(%0d,%0d)-(%0d,%0d) n=%0d color=%h refused=%b last=%b",
                       w.x0, w.y0, w.x1, w.y1, w.count, w.color, w.refused, w.last);
   endfunction

   function void check_window(window_type got);
      window_type want;
      string      bad;
      windows_checked++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("ERROR: unexpected window %s", show(got));
         return;
      end
      want = pending.pop_front();
      bad = "";
      if (got.x0 !== want.x0)           bad = {bad, " x0"};
      if (got.y0 !== want.y0)           bad = {bad, " y0"};
      if (got.x1 !== want.x1)           bad = {bad, " x1"};
      if (got.y1 !== want.y1)           bad = {bad, " y1"};
      if (got.count !== want.count)     bad = {bad, " pixel_count"};
      if (got.color !== want.color)     bad = {bad, " color_packed"};
      if (got.refused !== want.refused) bad = {bad, " refused"};
      if (got.last !== want.last)       bad = {bad, " last_segment"};
      if (bad != "") begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("ERROR: window field(s)%s differ at %0t", bad, $realtime);
            $display("   expected %s", show(want));
            $display("   actual   %s", show(got));
         end
      end
   endfunction

   function void flag_leftovers();
      if (pending.size() > 0) begin
         mismatches += pending.size();
         $display("ERROR: %0d expected windows never arrived", pending.size());
      end
   endfunction
endclass

module clipped_draw_window_generator_unit_tb;

   localparam int QuietLimit  = 5000;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 24;

   localparam cdwg_pkg::req_code_type  ReqSpare6 = 3'd6;
   localparam cdwg_pkg::req_code_type  ReqSpare7 = 3'd7;
   localparam cdwg_pkg::csr_index_type CsrSpare6 = 3'd6;
   localparam cdwg_pkg::csr_index_type CsrSpare7 = 3'd7;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [2:0]              req_type = '0;
   logic signed [15:0]      req_pos_x = '0;
   logic signed [15:0]      req_pos_y = '0;
   logic [15:0]             req_len_x = '0;
   logic [15:0]             req_len_y = '0;
   logic [7:0]              req_thickness = '0;
   logic [23:0]             req_color_rgb = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [15:0]             rsp_win_x0;
   logic [15:0]             rsp_win_y0;
   logic [15:0]             rsp_win_x1;
   logic [15:0]             rsp_win_y1;
   logic [20:0]             rsp_pixel_count;
   logic [15:0]             rsp_color_packed;
   logic                    rsp_refused;
   logic                    rsp_last_segment;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   cdwg_pkg::csr_index_type csr_index = '0;
   logic [10:0]             csr_wdata = '0;

   draw_window_checker window_check;
   window_type         rsp_window;
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 hold_requests = 0;
   int                 hold_served = 0;
   int                 hold_left = 0;
   int                 quiet_cycles = 0;
   int                 requests_sent = 0;
   int                 settings_applied = 1;
   int                 aim_w = 320;
   int                 aim_h = 240;

   clipped_draw_window_generator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_len_x        (req_len_x),
      .req_len_y        (req_len_y),
      .req_thickness    (req_thickness),
      .req_color_rgb    (req_color_rgb),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_win_x0       (rsp_win_x0),
      .rsp_win_y0       (rsp_win_y0),
      .rsp_win_x1       (rsp_win_x1),
      .rsp_win_y1       (rsp_win_y1),
      .rsp_pixel_count  (rsp_pixel_count),
      .rsp_color_packed (rsp_color_packed),
      .rsp_refused      (rsp_refused),
      .rsp_last_segment (rsp_last_segment),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: check accepted windows, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_window.x0      = rsp_win_x0;
         rsp_window.y0      = rsp_win_y0;
         rsp_window.x1      = rsp_win_x1;
         rsp_window.y1      = rsp_win_y1;
         rsp_window.count   = rsp_pixel_count;
         rsp_window.color   = rsp_color_packed;
         rsp_window.refused = rsp_refused;
         rsp_window.last    = rsp_last_segment;
         window_check.check_window(rsp_window);
      end
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("ERROR: no handshake for %0d cycles, %0d windows outstanding",
                  QuietLimit, window_check.pending.size());
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic draw_req_type make_req(cdwg_pkg::req_code_type code, int x, int y,
                                             int lx, int ly, int t, logic [23:0] color);
      draw_req_type r;
      r.code      = code;
      r.pos_x     = 16'(x);
      r.pos_y     = 16'(y);
      r.len_x     = 16'(lx);
      r.len_y     = 16'(ly);
      r.thickness = 8'(t);
      r.color     = color;
      return r;
   endfunction

   function automatic int pick_len(int span);
      case ($urandom_range(9))
         0:       return $urandom_range(65535);
         1:       return $urandom_range(2);
         default: return $urandom_range(span / 2 + 2);
      endcase
   endfunction

   function automatic draw_req_type random_request();
      cdwg_pkg::req_code_type code;
      int                     x;
      int                     y;
      int                     t;
      if ($urandom_range(99) < 4)
         code = $urandom_range(1) ? ReqSpare6 : ReqSpare7;
      else
         code = cdwg_pkg::req_code_type'($urandom_range(5));
      if ($urandom_range(9) == 0) begin
         x = $urandom_range(65535);
         y = $urandom_range(65535);
      end else begin
         x = $urandom_range(aim_w + 40) - 20;
         y = $urandom_range(aim_h + 40) - 20;
      end
      t = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(12);
      return make_req(code, x, y, pick_len(aim_w), pick_len(aim_h), t, 24'($urandom));
   endfunction

   task automatic send_request(draw_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= r.code;
      req_pos_x     <= r.pos_x;
      req_pos_y     <= r.pos_y;
      req_len_x     <= r.len_x;
      req_len_y     <= r.len_y;
      req_thickness <= r.thickness;
      req_color_rgb <= r.color;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      window_check.note_request(r);
      requests_sent++;
   endtask

   task automatic send_random(int count);
      repeat (count) send_request(random_request());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (window_check.pending.size() > 0) @(posedge clock);
   endtask

   task automatic write_csr(cdwg_pkg::csr_index_type idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      window_check.write_reg(idx, value);
   endtask

   // registers change only with nothing in flight
   task automatic apply_region(int xlo, int ylo, int xhi, int yhi, int pw, int ph,
                               bit poke_spare);
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      write_csr(cdwg_pkg::CsrClipXMin, 11'(xlo));
      write_csr(cdwg_pkg::CsrClipYMin, 11'(ylo));
      write_csr(cdwg_pkg::CsrClipXMax, 11'(xhi));
      write_csr(cdwg_pkg::CsrClipYMax, 11'(yhi));
      write_csr(cdwg_pkg::CsrPanelWidth, 11'(pw));
      write_csr(cdwg_pkg::CsrPanelHeight, 11'(ph));
      if (poke_spare) begin
         write_csr(CsrSpare6, 11'h7FF);
         write_csr(CsrSpare7, 11'h7FF);
      end
      csr_valid <= 1'b0;
      repeat (4) @(posedge clock);
      aim_w = window_check.capped(11'(xhi)) < window_check.capped(11'(pw))
            ? window_check.capped(11'(xhi)) : window_check.capped(11'(pw));
      aim_h = window_check.capped(11'(yhi)) < window_check.capped(11'(ph))
            ? window_check.capped(11'(yhi)) : window_check.capped(11'(ph));
      if (aim_w < 8) aim_w = 8;
      if (aim_h < 8) aim_h = 8;
      settings_applied++;
   endtask

   initial begin
      window_check = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      req_idle_pct = 9;
      rsp_idle_pct = 69;
      // directed part on the reset region (320 x 240)
      send_request(make_req(cdwg_pkg::ReqPixel, 0, 0, 0, 0, 0, 24'hFFFFFF));
      send_request(make_req(cdwg_pkg::ReqPixel, 319, 239, 0, 0, 0, 24'h000000));
      send_request(make_req(cdwg_pkg::ReqPixel, 320, 0, 0, 0, 0, 24'h00FF00));
      send_request(make_req(cdwg_pkg::ReqPixel, -1, -1, 0, 0, 0, 24'h0000FF));
      send_request(make_req(cdwg_pkg::ReqPixel, -32768, 32767, 65535, 65535, 255,
                            24'hFF0000));
      send_request(make_req(cdwg_pkg::ReqFill, 10, 20, 30, 40, 0, 24'hF80000));
      send_request(make_req(cdwg_pkg::ReqFill, -32768, -32768, 65535, 65535, 0,
                            24'h07E0F8));
      send_request(make_req(cdwg_pkg::ReqFill, 50, 50, 0, 10, 0, 24'h808080));
      send_request(make_req(cdwg_pkg::ReqOutline, 5, 5, 1, 1, 0, 24'h123456));
      send_request(make_req(cdwg_pkg::ReqOutline, 5, 5, 1, 5, 0, 24'h654321));
      send_request(make_req(cdwg_pkg::ReqOutline, 5, 5, 6, 2, 0, 24'hABCDEF));
      send_request(make_req(cdwg_pkg::ReqOutline, 300, 200, 40, 30, 0, 24'h00FFFF));
      send_request(make_req(cdwg_pkg::ReqOutline, -10, -10, 30, 30, 0, 24'hFFFF00));
      send_request(make_req(cdwg_pkg::ReqOutline, 20, 20, 0, 5, 0, 24'hFF00FF));
      send_request(make_req(cdwg_pkg::ReqHline, 0, 100, 320, 0, 0, 24'h0F0F0F));
      send_request(make_req(cdwg_pkg::ReqHline, 0, 0, 320, 0, 5, 24'hF0F0F0));
      send_request(make_req(cdwg_pkg::ReqHline, -100, 120, 65535, 0, 255, 24'h5A5A5A));
      send_request(make_req(cdwg_pkg::ReqHline, 32767, 10, 65535, 0, 3, 24'hA5A5A5));
      send_request(make_req(cdwg_pkg::ReqVline, 160, 0, 0, 240, 1, 24'h3C3C3C));
      send_request(make_req(cdwg_pkg::ReqVline, 319, 10, 0, 50, 4, 24'hC3C3C3));
      send_request(make_req(cdwg_pkg::ReqClear, 0, 0, 0, 0, 0, 24'h123456));
      send_request(make_req(ReqSpare6, 10, 10, 10, 10, 10, 24'h111111));
      send_request(make_req(ReqSpare7, 10, 10, 10, 10, 10, 24'h222222));
      send_request(make_req(cdwg_pkg::ReqClear, -5, -5, 9, 9, 9, 24'hFFFFFF));

      // largest region: values above 1024 act as 1024
      apply_region(0, 0, 2047, 2047, 2047, 2047, 1'b0);
      send_request(make_req(cdwg_pkg::ReqClear, 0, 0, 0, 0, 0, 24'hFFFFFF));
      send_request(make_req(cdwg_pkg::ReqFill, -1, -1, 2000, 2000, 0, 24'h000000));
      hold_requests++;  // long output stall while requests keep coming
      send_random(20);

      // a single drawable pixel in the far corner
      apply_region(1023, 1023, 1024, 1024, 1024, 1024, 1'b0);
      send_request(make_req(cdwg_pkg::ReqPixel, 1023, 1023, 0, 0, 0, 24'h89ABCD));
      send_request(make_req(cdwg_pkg::ReqOutline, 1020, 1020, 4, 4, 0, 24'h13579B));
      send_random(6);

      req_idle_pct = 69;
      rsp_idle_pct = 9;
      // clip region partly outside a narrow panel
      apply_region(7, 3, 200, 150, 160, 300, 1'b0);
      send_random(20);
      wait_drained();
      send_random(20);

      // nothing drawable at all; spare indexes must be ignored
      apply_region(0, 0, 0, 0, 0, 0, 1'b1);
      send_request(make_req(cdwg_pkg::ReqClear, 0, 0, 0, 0, 0, 24'hFFFFFF));
      send_random(6);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      // random region; bit 10 of the min edges is dropped by the 10-bit registers
      apply_region($urandom_range(120) | ($urandom_range(1) << 10),
                   $urandom_range(120) | ($urandom_range(1) << 10),
                   $urandom_range(200, 1100), $urandom_range(200, 1100),
                   $urandom_range(100, 1100), $urandom_range(100, 1100), 1'b0);
      send_random(40);

      apply_region(0, 0, 320, 240, 320, 240, 1'b0);
      send_random(30);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      window_check.flag_leftovers();
      $display("Run covered %0d draw requests over %0d register settings, %0d windows checked",
               requests_sent, settings_applied, window_check.windows_checked);
      $display("Idle mixes: sender-light, receiver-light and none; one long output stall");
      if (window_check.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/cdwg_pkg.sv
sv/cdwg_front.sv
sv/cdwg_queue.sv
sv/cdwg_back.sv
sv/clipped_draw_window_generator_unit.sv
verif/clipped_draw_window_generator_unit_tb.sv
